// ===== hw/rtl/display_link_frame_engine_top_macros.svh =====
// Assertion macros for the display link frame engine.
// Used by the queue and back-end modules; no other dependencies.
`ifndef DISPLAY_LINK_FRAME_ENGINE_TOP_MACROS_SVH
`define DISPLAY_LINK_FRAME_ENGINE_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define DLFE_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define DLFE_ASSERT_NEXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("assertion failed");
// condition never holds
`define DLFE_ASSERT_NEVER(lbl, ck, rn, a) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(a)) \
		else $error("assertion failed");
`else
`define DLFE_ASSERT_IMP(lbl, ck, rn, a, c)
`define DLFE_ASSERT_NEXT(lbl, ck, rn, a, c)
`define DLFE_ASSERT_NEVER(lbl, ck, rn, a)
`endif
`endif

// ===== hw/rtl/dlfe_pkg.sv =====
// Shared types and constants of the display link frame engine.
// No dependencies; used by every module of the block.
package dlfe_pkg;

	localparam logic [7:0] ACK_BYTE  = 8'h06;
	localparam logic [7:0] DC1_BYTE  = 8'h11;
	localparam logic [7:0] DC2_BYTE  = 8'h12;
	localparam logic [7:0] ESC_BYTE  = 8'h1B;
	localparam logic [7:0] ONE_BYTE  = 8'h01;
	localparam logic [7:0] REQ_BYTE  = 8'h53;
	localparam logic [7:0] POLL_BYTE = 8'h00;
	localparam logic [7:0] RD_SUM    = 8'(DC2_BYTE + ONE_BYTE + REQ_BYTE);

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_WR_BEGIN = 2'd0,
		CMD_WR_BYTE  = 2'd1,
		CMD_RD_START = 2'd2,
		CMD_REPLY    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_PROGRESS = 3'd0,
		ST_WR_ACK   = 3'd1,
		ST_WR_NACK  = 3'd2,
		ST_NOTHING  = 3'd3,
		ST_RD_DONE  = 3'd4,
		ST_ORDER    = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		K_WR_HDR  = 3'd0,
		K_WR_PAY  = 3'd1,
		K_RD_REQ  = 3'd2,
		K_STATUS  = 3'd3,
		K_POLL    = 3'd4,
		K_RD_BYTE = 3'd5,
		K_RD_DONE = 3'd6
	} kind_t;

	// one classified input: the back end expands it into its result words
	typedef struct packed {
		kind_t       kind;
		logic        fin;
		logic [7:0]  b0;
		logic [7:0]  b1;
		status_t     st;
		logic [8:0]  cnt;
	} job_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        expects_reply;
		logic        rx_valid;
		logic [7:0]  rx_byte;
		logic        rx_last;
		logic [8:0]  read_count;
		status_t     st;
	} item_t;

endpackage

// ===== hw/rtl/dlfe_front.sv =====
// Front end: accepts input words, tracks the protocol phase and classifies
// each word into a job. Depends on dlfe_pkg.
module dlfe_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             q_full,
	input  logic [1:0]       command,
	input  logic [7:0]       data_byte,
	input  logic [7:0]       payload_length,
	input  logic             sbuf_line,
	output logic             push,
	output dlfe_pkg::job_t   job
);

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_WR_PAY  = 7'b0000010,
		PH_WR_ACK  = 7'b0000100,
		PH_RD_ACK  = 7'b0001000,
		PH_RD_DC1  = 7'b0010000,
		PH_RD_LEN  = 7'b0100000,
		PH_RD_DATA = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [8:0]  rem_q, rem_d;
	logic [7:0]  sum_q, sum_d;
	logic [8:0]  dlv_q, dlv_d;

	logic [7:0]  len_byte;
	logic [7:0]  hdr_sum;
	logic [7:0]  pay_sum;
	logic [8:0]  rem_dec;
	logic [8:0]  dlv_inc;
	logic [7:0]  want;

	assign push     = in_valid && !q_full;
	assign len_byte = payload_length + 8'd1;
	assign hdr_sum  = dlfe_pkg::DC1_BYTE + len_byte + dlfe_pkg::ESC_BYTE;
	assign pay_sum  = sum_q + data_byte;
	assign rem_dec  = rem_q - 9'd1;
	assign dlv_inc  = dlv_q + 9'd1;
	assign want     = (phase_q == PH_RD_ACK) ? dlfe_pkg::ACK_BYTE : dlfe_pkg::DC1_BYTE;

	always_comb begin
		phase_d  = phase_q;
		rem_d    = rem_q;
		sum_d    = sum_q;
		dlv_d    = dlv_q;
		job      = '0;
		job.kind = dlfe_pkg::K_STATUS;
		job.st   = dlfe_pkg::ST_ORDER;
		case (dlfe_pkg::cmd_t'(command))
			dlfe_pkg::CMD_WR_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					job.kind = dlfe_pkg::K_WR_HDR;
					job.b0   = len_byte;
					job.b1   = hdr_sum;
					job.fin  = (payload_length == 8'd0);
					job.st   = dlfe_pkg::ST_PROGRESS;
					sum_d    = hdr_sum;
					rem_d    = {1'b0, payload_length};
					phase_d  = (payload_length == 8'd0) ? PH_WR_ACK : PH_WR_PAY;
				end
			end
			dlfe_pkg::CMD_WR_BYTE: begin
				if (phase_q == PH_WR_PAY) begin
					job.kind = dlfe_pkg::K_WR_PAY;
					job.b0   = data_byte;
					job.b1   = pay_sum;
					job.fin  = (rem_dec == 9'd0);
					job.st   = dlfe_pkg::ST_PROGRESS;
					sum_d    = pay_sum;
					rem_d    = rem_dec;
					if (rem_dec == 9'd0)
						phase_d = PH_WR_ACK;
				end
			end
			dlfe_pkg::CMD_RD_START: begin
				if (phase_q == PH_IDLE) begin
					if (sbuf_line) begin
						job.st = dlfe_pkg::ST_NOTHING;
					end else begin
						job.kind = dlfe_pkg::K_RD_REQ;
						job.st   = dlfe_pkg::ST_PROGRESS;
						phase_d  = PH_RD_ACK;
					end
				end
			end
			dlfe_pkg::CMD_REPLY: begin
				if (phase_q == PH_WR_ACK) begin
					job.st  = (data_byte == dlfe_pkg::ACK_BYTE) ?
					          dlfe_pkg::ST_WR_ACK : dlfe_pkg::ST_WR_NACK;
					phase_d = PH_IDLE;
				end else if (phase_q == PH_RD_ACK || phase_q == PH_RD_DC1) begin
					if (data_byte != want) begin
						job.st  = dlfe_pkg::ST_NOTHING;
						phase_d = PH_IDLE;
					end else begin
						job.kind = dlfe_pkg::K_POLL;
						job.st   = dlfe_pkg::ST_PROGRESS;
						phase_d  = (phase_q == PH_RD_ACK) ? PH_RD_DC1 : PH_RD_LEN;
					end
				end else if (phase_q == PH_RD_LEN) begin
					job.kind = dlfe_pkg::K_POLL;
					job.st   = dlfe_pkg::ST_PROGRESS;
					rem_d    = {1'b0, data_byte} + 9'd1;
					dlv_d    = '0;
					phase_d  = PH_RD_DATA;
				end else if (phase_q == PH_RD_DATA) begin
					job.b0 = data_byte;
					rem_d  = rem_dec;
					dlv_d  = dlv_inc;
					if (rem_dec == 9'd0) begin
						job.kind = dlfe_pkg::K_RD_DONE;
						job.st   = dlfe_pkg::ST_RD_DONE;
						job.cnt  = dlv_inc;
						phase_d  = PH_IDLE;
					end else begin
						job.kind = dlfe_pkg::K_RD_BYTE;
						job.st   = dlfe_pkg::ST_PROGRESS;
					end
				end
			end
			default: begin
				job.st = dlfe_pkg::ST_ORDER;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			rem_q   <= '0;
			sum_q   <= '0;
			dlv_q   <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			sum_q   <= sum_d;
			dlv_q   <= dlv_d;
		end
	end

endmodule

// ===== hw/rtl/dlfe_queue.sv =====
// Short job queue between front and back end, built from registers.
// Depends on dlfe_pkg and the assertion macro header.
`include "display_link_frame_engine_top_macros.svh"
module dlfe_queue #(
	parameter int DEPTH = dlfe_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  dlfe_pkg::job_t   push_job,
	input  logic             pop,
	output logic             empty,
	output logic             full,
	output dlfe_pkg::job_t   head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dlfe_pkg::job_t   slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

	`DLFE_ASSERT_NEVER(a_no_push_full, clk, arst_n, push && full)
	`DLFE_ASSERT_NEVER(a_no_pop_empty, clk, arst_n, pop && empty)
	`DLFE_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))

endmodule

// ===== hw/rtl/dlfe_back.sv =====
// Back end: expands queued jobs into result words, one per cycle unless the
// output stalls, into the output register. Depends on dlfe_pkg and the assertion macro header.
`include "display_link_frame_engine_top_macros.svh"
module dlfe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  dlfe_pkg::job_t   head,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output dlfe_pkg::item_t  item,
	output logic             item_last
);

	logic              head_valid;
	logic              load;
	logic              job_end;
	logic [2:0]        idx_q;
	logic [2:0]        head_len;
	dlfe_pkg::item_t   item_d;
	dlfe_pkg::item_t   item_q;
	logic              last_q;
	logic              valid_q;

	assign head_valid = !q_empty;
	assign load       = head_valid && (!valid_q || !out_stall);
	assign job_end    = (idx_q == head_len - 3'd1);
	assign pop        = load && job_end;

	always_comb begin
		case (head.kind)
			dlfe_pkg::K_WR_HDR: head_len = head.fin ? 3'd5 : 3'd3;
			dlfe_pkg::K_WR_PAY: head_len = head.fin ? 3'd3 : 3'd1;
			dlfe_pkg::K_RD_REQ: head_len = 3'd5;
			default:            head_len = 3'd1;
		endcase
	end

	// word idx_q of the head job
	always_comb begin
		item_d          = '0;
		item_d.st       = head.st;
		item_d.tx_valid = 1'b1;
		case (head.kind)
			dlfe_pkg::K_WR_HDR: begin
				case (idx_q)
					3'd0:    item_d.tx_byte = dlfe_pkg::DC1_BYTE;
					3'd1:    item_d.tx_byte = head.b0;
					3'd2:    item_d.tx_byte = dlfe_pkg::ESC_BYTE;
					3'd3:    item_d.tx_byte = head.b1;
					default: begin
						item_d.tx_byte       = dlfe_pkg::POLL_BYTE;
						item_d.expects_reply = 1'b1;
					end
				endcase
			end
			dlfe_pkg::K_WR_PAY: begin
				case (idx_q)
					3'd0:    item_d.tx_byte = head.b0;
					3'd1:    item_d.tx_byte = head.b1;
					default: begin
						item_d.tx_byte       = dlfe_pkg::POLL_BYTE;
						item_d.expects_reply = 1'b1;
					end
				endcase
			end
			dlfe_pkg::K_RD_REQ: begin
				case (idx_q)
					3'd0:    item_d.tx_byte = dlfe_pkg::DC2_BYTE;
					3'd1:    item_d.tx_byte = dlfe_pkg::ONE_BYTE;
					3'd2:    item_d.tx_byte = dlfe_pkg::REQ_BYTE;
					3'd3:    item_d.tx_byte = dlfe_pkg::RD_SUM;
					default: begin
						item_d.tx_byte       = dlfe_pkg::POLL_BYTE;
						item_d.expects_reply = 1'b1;
					end
				endcase
			end
			dlfe_pkg::K_POLL: begin
				item_d.tx_byte       = dlfe_pkg::POLL_BYTE;
				item_d.expects_reply = 1'b1;
			end
			dlfe_pkg::K_RD_BYTE: begin
				item_d.tx_byte       = dlfe_pkg::POLL_BYTE;
				item_d.expects_reply = 1'b1;
				item_d.rx_valid      = 1'b1;
				item_d.rx_byte       = head.b0;
			end
			dlfe_pkg::K_RD_DONE: begin
				item_d.tx_valid   = 1'b0;
				item_d.rx_valid   = 1'b1;
				item_d.rx_byte    = head.b0;
				item_d.rx_last    = 1'b1;
				item_d.read_count = head.cnt;
			end
			default: begin
				item_d.tx_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item_d;
			last_q <= job_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (!valid_q || !out_stall)
				valid_q <= head_valid;
			if (load)
				idx_q <= job_end ? 3'd0 : idx_q + 3'd1;
		end
	end

	assign out_valid = valid_q;
	assign item      = item_q;
	assign item_last = last_q;

	`DLFE_ASSERT_IMP(a_idx_in_job, clk, arst_n, head_valid, idx_q < head_len)
	`DLFE_ASSERT_NEXT(a_idx_clear, clk, arst_n, pop, idx_q == 3'd0)

endmodule

// ===== hw/rtl/display_link_frame_engine_top.sv =====
// Display link frame engine: host-side framer for a byte-exchange display
// link. Each accepted input word yields one to five result words, delivered
// one per cycle from the output register while the output does not stall,
// so an input occupies the back end until all of the words it causes are
// delivered (five at most, one for replies and status). The front end takes
// a new input word every cycle while the job queue (QDEPTH entries) has room,
// also while a result is still stalled. No memory and no clearing pass after reset.
module display_link_frame_engine_top #(
	parameter int QDEPTH = dlfe_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  payload_length,
	input  logic        sbuf_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        expects_reply,
	output logic        rx_valid,
	output logic [7:0]  rx_byte,
	output logic        rx_last,
	output logic [8:0]  read_count,
	output logic [2:0]  status,
	output logic        item_last
);

	logic              push;
	logic              pop;
	logic              q_empty;
	logic              q_full;
	dlfe_pkg::job_t    push_job;
	dlfe_pkg::job_t    head;
	dlfe_pkg::item_t   item;

	assign in_stall = q_full;

	dlfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.q_full         (q_full),
		.command        (command),
		.data_byte      (data_byte),
		.payload_length (payload_length),
		.sbuf_line      (sbuf_line),
		.push           (push),
		.job            (push_job)
	);

	dlfe_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.empty    (q_empty),
		.full     (q_full),
		.head     (head)
	);

	dlfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.item      (item),
		.item_last (item_last)
	);

	assign tx_valid      = item.tx_valid;
	assign tx_byte       = item.tx_byte;
	assign expects_reply = item.expects_reply;
	assign rx_valid      = item.rx_valid;
	assign rx_byte       = item.rx_byte;
	assign rx_last       = item.rx_last;
	assign read_count    = item.read_count;
	assign status        = item.st;

endmodule

// ===== tb/display_link_frame_checker.sv =====
`timescale 1ns / 1ps
// Checker for the display link frame engine: watches both word channels,
// predicts the result words of each accepted input word and compares them.
// Depends on dlfe_pkg for command and status codes and the link bytes.
module display_link_frame_checker
	import dlfe_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] command,
	input  logic [7:0] data_byte,
	input  logic [7:0] payload_length,
	input  logic       sbuf_line,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic       tx_valid,
	input  logic [7:0] tx_byte,
	input  logic       expects_reply,
	input  logic       rx_valid,
	input  logic [7:0] rx_byte,
	input  logic       rx_last,
	input  logic [8:0] read_count,
	input  logic [2:0] status,
	input  logic       item_last,
	output int         fail_count,
	output int         pending,
	output int         checked
);

	typedef enum logic [3:0] {
		LP_IDLE,
		LP_WR_PAYLOAD,
		LP_WR_REPLY,
		LP_RD_ACK,
		LP_RD_DC1,
		LP_RD_LEN,
		LP_RD_DATA
	} link_phase_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       expects_reply;
		logic       rx_valid;
		logic [7:0] rx_byte;
		logic       rx_last;
		logic [8:0] read_count;
		status_t    st;
		logic       item_last;
	} link_word_t;

	link_word_t  expected_words[$];
	link_phase_t phase_q;
	logic [8:0]  remaining_q;
	logic [7:0]  sum_q;
	logic [8:0]  delivered_q;
	int          fails_q;
	int          checked_q;

	function automatic link_word_t tx_word(logic [7:0] b, logic er);
		link_word_t w;
		w = '0;
		w.tx_valid = 1'b1;
		w.tx_byte = b;
		w.expects_reply = er;
		w.st = ST_PROGRESS;
		return w;
	endfunction

	function automatic link_word_t status_word(status_t s);
		link_word_t w;
		w = '0;
		w.st = s;
		return w;
	endfunction

	function automatic string word_text(link_word_t w);
		return $sformatf("tx %0b:%02h er %0b rx %0b:%02h last %0b cnt %0d st %0d end %0b",
			w.tx_valid, w.tx_byte, w.expects_reply, w.rx_valid, w.rx_byte,
			w.rx_last, w.read_count, w.st, w.item_last);
	endfunction

	task automatic predict_frame(logic [1:0] c, logic [7:0] db, logic [7:0] len, logic sb);
		link_word_t words[5];
		int         n;
		logic [7:0] lb;
		logic [7:0] req_sum;
		logic [7:0] want;
		n = 0;
		req_sum = DC2_BYTE + ONE_BYTE + REQ_BYTE;
		if (c == CMD_WR_BEGIN && phase_q == LP_IDLE) begin
			lb = len + 8'd1;
			words[0] = tx_word(DC1_BYTE, 1'b0);
			words[1] = tx_word(lb, 1'b0);
			words[2] = tx_word(ESC_BYTE, 1'b0);
			n = 3;
			sum_q = DC1_BYTE + lb + ESC_BYTE;
			remaining_q = {1'b0, len};
			if (len == 8'd0) begin
				// empty write: checksum and poll follow the header at once
				words[3] = tx_word(sum_q, 1'b0);
				words[4] = tx_word(POLL_BYTE, 1'b1);
				n = 5;
				phase_q = LP_WR_REPLY;
			end else begin
				phase_q = LP_WR_PAYLOAD;
			end
		end else if (c == CMD_WR_BYTE && phase_q == LP_WR_PAYLOAD) begin
			words[0] = tx_word(db, 1'b0);
			n = 1;
			sum_q = sum_q + db;
			remaining_q = remaining_q - 9'd1;
			if (remaining_q == 9'd0) begin
				words[1] = tx_word(sum_q, 1'b0);
				words[2] = tx_word(POLL_BYTE, 1'b1);
				n = 3;
				phase_q = LP_WR_REPLY;
			end
		end else if (c == CMD_RD_START && phase_q == LP_IDLE) begin
			if (sb) begin
				words[0] = status_word(ST_NOTHING);
				n = 1;
			end else begin
				words[0] = tx_word(DC2_BYTE, 1'b0);
				words[1] = tx_word(ONE_BYTE, 1'b0);
				words[2] = tx_word(REQ_BYTE, 1'b0);
				words[3] = tx_word(req_sum, 1'b0);
				words[4] = tx_word(POLL_BYTE, 1'b1);
				n = 5;
				phase_q = LP_RD_ACK;
			end
		end else if (c == CMD_REPLY && phase_q == LP_WR_REPLY) begin
			words[0] = status_word(db == ACK_BYTE ? ST_WR_ACK : ST_WR_NACK);
			n = 1;
			phase_q = LP_IDLE;
		end else if (c == CMD_REPLY && (phase_q == LP_RD_ACK || phase_q == LP_RD_DC1)) begin
			want = (phase_q == LP_RD_ACK) ? ACK_BYTE : DC1_BYTE;
			n = 1;
			if (db != want) begin
				words[0] = status_word(ST_NOTHING);
				phase_q = LP_IDLE;
			end else begin
				words[0] = tx_word(POLL_BYTE, 1'b1);
				phase_q = (phase_q == LP_RD_ACK) ? LP_RD_DC1 : LP_RD_LEN;
			end
		end else if (c == CMD_REPLY && phase_q == LP_RD_LEN) begin
			// length 255 means 256 bytes: keep the ninth bit
			remaining_q = {1'b0, db} + 9'd1;
			delivered_q = 9'd0;
			words[0] = tx_word(POLL_BYTE, 1'b1);
			n = 1;
			phase_q = LP_RD_DATA;
		end else if (c == CMD_REPLY && phase_q == LP_RD_DATA) begin
			delivered_q = delivered_q + 9'd1;
			remaining_q = remaining_q - 9'd1;
			n = 1;
			if (remaining_q == 9'd0) begin
				words[0] = status_word(ST_RD_DONE);
				words[0].rx_valid = 1'b1;
				words[0].rx_byte = db;
				words[0].rx_last = 1'b1;
				words[0].read_count = delivered_q;
				phase_q = LP_IDLE;
			end else begin
				words[0] = tx_word(POLL_BYTE, 1'b1);
				words[0].rx_valid = 1'b1;
				words[0].rx_byte = db;
			end
		end else begin
			// command does not fit the phase: report, leave state alone
			words[0] = status_word(ST_ORDER);
			n = 1;
		end
		words[n - 1].item_last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_words.push_back(words[i]);
	endtask

	task automatic check_word();
		link_word_t got;
		link_word_t want;
		got.tx_valid = tx_valid;
		got.tx_byte = tx_byte;
		got.expects_reply = expects_reply;
		got.rx_valid = rx_valid;
		got.rx_byte = rx_byte;
		got.rx_last = rx_last;
		got.read_count = read_count;
		got.st = status_t'(status);
		got.item_last = item_last;
		if (expected_words.size() == 0) begin
			fails_q++;
			if (fails_q <= 10)
				$display("%0t: result word with none expected: %s", $time, word_text(got));
		end else begin
			want = expected_words.pop_front();
			checked_q++;
			if (got !== want) begin
				fails_q++;
				if (fails_q <= 10) begin
					$display("%0t: result word mismatch", $time);
					$display("  expected %s", word_text(want));
					$display("  actual   %s", word_text(got));
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q = LP_IDLE;
			remaining_q = '0;
			sum_q = '0;
			delivered_q = '0;
			fails_q = 0;
			checked_q = 0;
			expected_words.delete();
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// push before pop: a word leaving now is always from an older input
			if (in_valid && !in_stall)
				predict_frame(command, data_byte, payload_length, sbuf_line);
			if (out_valid && !out_stall)
				check_word();
			fail_count <= fails_q;
			pending <= expected_words.size();
			checked <= checked_q;
		end
	end

endmodule

// ===== tb/tb_display_link_frame_engine_top.sv =====
`timescale 1ns / 1ps
// Top of the display link frame engine testbench: clock, reset, word stimulus
// with random gaps and stalls, and the verdict. Needs dlfe_pkg, the block and
// display_link_frame_checker.
module tb_display_link_frame_engine_top;
	import dlfe_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int LONG_HOLD   = 120;
	localparam int TOTAL_WORDS = 380;

	typedef enum int {
		RD_NO_DATA,
		RD_BAD_ACK,
		RD_BAD_DC1,
		RD_FULL
	} read_mode_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] command = 2'd0;
	logic [7:0] data_byte = 8'd0;
	logic [7:0] payload_length = 8'd0;
	logic       sbuf_line = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       expects_reply;
	logic       rx_valid;
	logic [7:0] rx_byte;
	logic       rx_last;
	logic [8:0] read_count;
	logic [2:0] status;
	logic       item_last;

	int fail_count;
	int pending;
	int checked;
	int words_sent = 0;
	int cycles = 0;
	bit no_gaps = 1'b0;
	bit long_hold_done = 1'b0;

	display_link_frame_engine_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.data_byte(data_byte),
		.payload_length(payload_length),
		.sbuf_line(sbuf_line),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.expects_reply(expects_reply),
		.rx_valid(rx_valid),
		.rx_byte(rx_byte),
		.rx_last(rx_last),
		.read_count(read_count),
		.status(status),
		.item_last(item_last)
	);

	display_link_frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.data_byte(data_byte),
		.payload_length(payload_length),
		.sbuf_line(sbuf_line),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.expects_reply(expects_reply),
		.rx_valid(rx_valid),
		.rx_byte(rx_byte),
		.rx_last(rx_last),
		.read_count(read_count),
		.status(status),
		.item_last(item_last),
		.fail_count(fail_count),
		.pending(pending),
		.checked(checked)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 20);
	endfunction

	function automatic logic [7:0] rnd_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] byte_other_than(logic [7:0] b);
		logic [7:0] v;
		v = rnd_byte();
		while (v == b)
			v = rnd_byte();
		return v;
	endfunction

	// offer one word and hold it until accepted
	task automatic send_word(cmd_t c, logic [7:0] db, logic [7:0] len, logic sb);
		int gap;
		in_valid <= 1'b1;
		command <= c;
		data_byte <= db;
		payload_length <= len;
		sbuf_line <= sb;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// now and then slip in a command that does not fit the current phase
	task automatic maybe_noise(cmd_t want, bit at_idle);
		cmd_t c;
		if ($urandom_range(0, 99) < 8) begin
			if (at_idle) begin
				c = $urandom_range(0, 1) ? CMD_REPLY : CMD_WR_BYTE;
			end else begin
				c = cmd_t'($urandom_range(0, 3));
				while (c == want)
					c = cmd_t'($urandom_range(0, 3));
			end
			send_word(c, rnd_byte(), rnd_byte(), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_write(int len, bit acked);
		maybe_noise(CMD_WR_BEGIN, 1'b1);
		send_word(CMD_WR_BEGIN, rnd_byte(), len[7:0], 1'($urandom_range(0, 1)));
		for (int i = 0; i < len; i++) begin
			maybe_noise(CMD_WR_BYTE, 1'b0);
			send_word(CMD_WR_BYTE, rnd_byte(), rnd_byte(), 1'($urandom_range(0, 1)));
		end
		maybe_noise(CMD_REPLY, 1'b0);
		send_word(CMD_REPLY, acked ? ACK_BYTE : byte_other_than(ACK_BYTE), rnd_byte(),
			1'($urandom_range(0, 1)));
	endtask

	task automatic run_read(read_mode_t mode, int rlen);
		maybe_noise(CMD_RD_START, 1'b1);
		send_word(CMD_RD_START, rnd_byte(), rnd_byte(), mode == RD_NO_DATA);
		if (mode == RD_NO_DATA)
			return;
		maybe_noise(CMD_REPLY, 1'b0);
		send_word(CMD_REPLY, mode == RD_BAD_ACK ? byte_other_than(ACK_BYTE) : ACK_BYTE,
			rnd_byte(), 1'($urandom_range(0, 1)));
		if (mode == RD_BAD_ACK)
			return;
		maybe_noise(CMD_REPLY, 1'b0);
		send_word(CMD_REPLY, mode == RD_BAD_DC1 ? byte_other_than(DC1_BYTE) : DC1_BYTE,
			rnd_byte(), 1'($urandom_range(0, 1)));
		if (mode == RD_BAD_DC1)
			return;
		maybe_noise(CMD_REPLY, 1'b0);
		send_word(CMD_REPLY, rlen[7:0], rnd_byte(), 1'($urandom_range(0, 1)));
		for (int i = 0; i <= rlen; i++) begin
			maybe_noise(CMD_REPLY, 1'b0);
			send_word(CMD_REPLY, rnd_byte(), rnd_byte(), 1'($urandom_range(0, 1)));
		end
	endtask

	// drop valid and wait until every expected result word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : receiver
		int run;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!long_hold_done && words_sent >= 150) begin
				// hold off long enough for the job queue to fill and stall input
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				run = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 6);
				repeat (run - 1) @(posedge clk);
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
					: $urandom_range(0, 2);
				if (run > 0) begin
					@(posedge clk);
					out_stall <= 1'b1;
					repeat (run - 1) @(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		int seq;
		int r;
		seq = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// nothing open yet: both are out of order
		send_word(CMD_WR_BYTE, 8'hFF, 8'hFF, 1'b1);
		send_word(CMD_REPLY, 8'hA5, 8'h00, 1'b0);
		// empty write, acked
		send_word(CMD_WR_BEGIN, 8'h00, 8'h00, 1'b0);
		send_word(CMD_REPLY, ACK_BYTE, 8'h7F, 1'b1);
		// one byte write, not acked
		send_word(CMD_WR_BEGIN, 8'h5A, 8'h01, 1'b1);
		send_word(CMD_WR_BYTE, 8'hFF, 8'h80, 1'b0);
		send_word(CMD_REPLY, 8'h00, 8'h00, 1'b0);
		// two byte write with stray commands in between
		send_word(CMD_WR_BEGIN, 8'h00, 8'h02, 1'b0);
		send_word(CMD_RD_START, 8'h00, 8'h00, 1'b0);
		send_word(CMD_WR_BYTE, 8'h00, 8'hFE, 1'b1);
		send_word(CMD_WR_BEGIN, 8'h33, 8'h05, 1'b0);
		send_word(CMD_WR_BYTE, 8'h80, 8'h01, 1'b0);
		send_word(CMD_WR_BEGIN, 8'h44, 8'h00, 1'b1);
		send_word(CMD_REPLY, ACK_BYTE, 8'h00, 1'b0);
		// read with no data pending
		send_word(CMD_RD_START, 8'hFF, 8'hFF, 1'b1);
		// read with bad ACK, then bad DC1
		send_word(CMD_RD_START, 8'h00, 8'h00, 1'b0);
		send_word(CMD_REPLY, 8'h07, 8'h00, 1'b0);
		send_word(CMD_RD_START, 8'h00, 8'h00, 1'b0);
		send_word(CMD_REPLY, ACK_BYTE, 8'h00, 1'b0);
		send_word(CMD_REPLY, 8'h10, 8'h00, 1'b0);
		// shortest full read, with a stray write byte
		send_word(CMD_RD_START, 8'h00, 8'h00, 1'b0);
		send_word(CMD_REPLY, ACK_BYTE, 8'h00, 1'b0);
		send_word(CMD_WR_BYTE, 8'h00, 8'h00, 1'b1);
		send_word(CMD_REPLY, DC1_BYTE, 8'h00, 1'b0);
		send_word(CMD_REPLY, 8'h00, 8'h00, 1'b0);
		send_word(CMD_REPLY, 8'hC3, 8'h00, 1'b1);

		while (words_sent < TOTAL_WORDS) begin
			no_gaps = ($urandom_range(0, 7) == 0);
			if (seq == 3) begin
				// longest read: length 255 means 256 bytes
				run_read(RD_FULL, 255);
			end else if ($urandom_range(0, 1)) begin
				r = $urandom_range(0, 99);
				run_write(r < 70 ? $urandom_range(0, 8)
					: r < 95 ? $urandom_range(9, 40) : $urandom_range(41, 254),
					$urandom_range(0, 3) != 0);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 10)
					run_read(RD_NO_DATA, 0);
				else if (r < 20)
					run_read(RD_BAD_ACK, 0);
				else if (r < 30)
					run_read(RD_BAD_DC1, 0);
				else
					run_read(RD_FULL, $urandom_range(0, 99) < 85 ? $urandom_range(0, 10)
						: $urandom_range(11, 80));
			end
			if (seq == 6)
				drain();
			seq++;
		end

		no_gaps = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		$display("Sent %0d input words in %0d sequences; %0d result words checked.",
			words_sent, seq, checked);
		$display("Writes of 0 to 254 bytes, reads of up to 256 bytes, stray commands, stalls.");
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
